/* rtl/deque_with_value_delete_core_macros.svh */
// assertion macros for the deque core
// no dependencies; included by deque_with_value_delete_core
`ifndef DEQUE_WITH_VALUE_DELETE_CORE_MACROS_SVH
`define DEQUE_WITH_VALUE_DELETE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, gated by the active-low reset
`define DQVD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deque core check failed");

// next-cycle implication, gated by the active-low reset
`define DQVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deque core check failed");

`else

`define DQVD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DQVD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/dqvd_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the deque core
// no dependencies
package dqvd_pkg;

  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;
  localparam int DQ_DEPTH = 64;

  localparam logic [DATA_W-1:0] DATA_EMPTY = '1;
  localparam logic [DATA_W-1:0] DATA_NONE  = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_POP_BACK   = 3'd1,
    MODE_PUSH_FRONT = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_DELETE     = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_READ  = 2'd1,
    S_SCAN  = 2'd2,
    S_SHIFT = 2'd3
  } state_e;

endpackage

/* rtl/deque_with_value_delete_core.sv */
`timescale 1ns / 1ps
// deque core: sequencer, pointers and result register around one entry ram
// depends on dqvd_pkg, dqvd_ram and deque_with_value_delete_core_macros.svh
//
// Usage
//   A request (mode_i, value_i) is taken at a rising edge with start_i high
//   and busy_o low. Exactly one result per request comes back on data_out_o,
//   status_o and occupancy_o, shown for one cycle with result_valid_o high.
//   The receiver cannot stall; results are never held.
// Timing and throughput
//   Pushes and unused mode codes: result in the cycle after the transaction,
//   busy_o stays low, so one request per cycle. A pop or a delete on an empty
//   queue answers the same way.
//   Pops: one ram read and busy_o high for one cycle in S_READ; the read data
//   is registered in the ram, then in the result register, so pops do not overlap.
//   Delete: one ram read per cycle, first walking from the front to the
//   match, then moving each later entry one place forward. busy_o stays high
//   for the whole walk, and the result shows in the first cycle with busy_o
//   low again. The single ram read port sets the pace of the walk.
// Reset
//   rst_ni clears front pointer and count: the queue is empty at once. The
//   ram is not cleared; entries are only read after they have been written.
module deque_with_value_delete_core #(
  parameter int DEPTH = dqvd_pkg::DQ_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic        [dqvd_pkg::MODE_W-1:0]   mode_i,
  input  logic signed [dqvd_pkg::DATA_W-1:0]   value_i,
  output logic                                 result_valid_o,
  output logic signed [dqvd_pkg::DATA_W-1:0]   data_out_o,
  output logic        [dqvd_pkg::STATUS_W-1:0] status_o,
  output logic        [dqvd_pkg::OCC_W-1:0]    occupancy_o
);

  import dqvd_pkg::*;

  `include "deque_with_value_delete_core_macros.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  state_e state_q, state_d;

  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     off_q, off_d;
  logic [DATA_W-1:0] val_q, val_d;

  logic                res_vld_q, res_vld_d;
  logic [DATA_W-1:0]   res_data_q, res_data_d;
  logic [STATUS_W-1:0] res_st_q, res_st_d;
  logic [OCC_W-1:0]    res_occ_q, res_occ_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic          accept, empty, full, match, last;
  logic [AW-1:0] front_inc, front_dec;
  logic [CW-1:0] off_nx;
  logic [CW+OCC_W-1:0] occ_ext;

  // ring position of an offset counted from the front
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] f, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(f) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign accept    = start_i && (state_q == S_IDLE);
  assign empty     = (count_q == '0);
  assign full      = (count_q == FULL_CNT);
  assign front_inc = (front_q == LAST_SLOT) ? '0 : front_q + AW'(1);
  assign front_dec = (front_q == '0) ? LAST_SLOT : front_q - AW'(1);
  assign off_nx    = off_q + CW'(1);
  assign match     = (ram_rdata == val_q);
  assign last      = (off_nx == count_q);

  dqvd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((mode_i == MODE_POP_BACK || mode_i == MODE_POP_FRONT) && !empty) begin
            state_d = S_READ;
          end else if (mode_i == MODE_DELETE && !empty) begin
            state_d = S_SCAN;
          end
        end
      end
      S_READ: state_d = S_IDLE;
      S_SCAN: begin
        if (last) begin
          state_d = S_IDLE;
        end else if (match) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath, ram control and result
  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    off_d      = off_q;
    val_d      = val_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    res_vld_d  = 1'b0;
    res_data_d = DATA_NONE;
    res_st_d   = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode_i)
            MODE_PUSH_BACK: begin
              res_vld_d = 1'b1;
              if (full) begin
                res_st_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(front_q, count_q);
                ram_wdata = value_i;
                count_d   = count_q + CW'(1);
              end
            end
            MODE_PUSH_FRONT: begin
              res_vld_d = 1'b1;
              if (full) begin
                res_st_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                ram_wdata = value_i;
                front_d   = front_dec;
                count_d   = count_q + CW'(1);
              end
            end
            MODE_POP_BACK: begin
              if (empty) begin
                res_vld_d  = 1'b1;
                res_data_d = DATA_EMPTY;
                res_st_d   = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = slot_of(front_q, count_q - CW'(1));
                count_d   = count_q - CW'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                res_vld_d  = 1'b1;
                res_data_d = DATA_EMPTY;
                res_st_d   = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_q;
                front_d   = front_inc;
                count_d   = count_q - CW'(1);
              end
            end
            MODE_DELETE: begin
              val_d = value_i;
              off_d = '0;
              if (empty) begin
                res_vld_d = 1'b1;
                res_st_d  = ST_NOT_FOUND;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_q;
              end
            end
            default: begin
              res_vld_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_vld_d  = 1'b1;
        res_data_d = ram_rdata;
      end
      S_SCAN: begin
        // read ahead of the compare, one entry per cycle
        ram_re    = !last;
        ram_raddr = slot_of(front_q, off_nx);
        if (last) begin
          res_vld_d = 1'b1;
          if (match) begin
            count_d = count_q - CW'(1);
          end else begin
            res_st_d = ST_NOT_FOUND;
          end
        end else begin
          off_d = off_nx;
        end
      end
      S_SHIFT: begin
        // entry at off_q moves one place toward the front
        ram_we    = 1'b1;
        ram_waddr = slot_of(front_q, off_q - CW'(1));
        ram_wdata = ram_rdata;
        ram_re    = !last;
        ram_raddr = slot_of(front_q, off_nx);
        if (last) begin
          res_vld_d = 1'b1;
          count_d   = count_q - CW'(1);
        end else begin
          off_d = off_nx;
        end
      end
      default: ;
    endcase
  end

  assign occ_ext   = {{OCC_W{1'b0}}, count_d};
  assign res_occ_d = occ_ext[OCC_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      off_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      off_q     <= off_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    if (res_vld_d) begin
      res_data_q <= res_data_d;
      res_st_q   <= res_st_d;
      res_occ_q  <= res_occ_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign data_out_o     = res_data_q;
  assign status_o       = res_st_q;
  assign occupancy_o    = res_occ_q;

  `DQVD_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= FULL_CNT)
  `DQVD_ASSERT_NEXT(a_push_result, clk_i, rst_ni,
    accept && (mode_i == MODE_PUSH_BACK || mode_i == MODE_PUSH_FRONT), result_valid_o)
  `DQVD_ASSERT_NEXT(a_pop_result, clk_i, rst_ni, state_q == S_READ, result_valid_o)
  `DQVD_ASSERT_IMPL(a_walk_in_range, clk_i, rst_ni,
    state_q == S_SCAN || state_q == S_SHIFT, off_q < count_q)

endmodule

/* rtl/dqvd_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module dqvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// self-checking bench for deque_with_value_delete_core: directed table, then random requests
// depends on dqvd_pkg and the deque core rtl
module tb;
  import dqvd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI  = 3'd7;

  localparam int DIR_N        = 23;
  localparam int POOL_N       = 6;
  localparam int RAND_ITEMS   = 1500;
  localparam int PHASES       = 6;
  localparam int DRAIN_CYCLES = 2 * DQ_DEPTH + 8;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occ;
  } deque_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    logic              typed;
    deque_result_t     res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [MODE_W-1:0] mode_i;
  logic signed [DATA_W-1:0] value_i;
  logic result_valid_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic [STATUS_W-1:0] status_o;
  logic [OCC_W-1:0] occupancy_o;

  // entries held by the bench's own copy of the deque, front first
  logic [DATA_W-1:0] model_entries [$];
  deque_result_t pending_results [$];
  stim_row_t dir_rows [DIR_N];
  logic [DATA_W-1:0] value_pool [POOL_N];
  int errors = 0;
  int stall_count = 0;

  always #5 clk_i = ~clk_i;

  deque_with_value_delete_core #(
    .DEPTH(DQ_DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .value_i       (value_i),
    .result_valid_o(result_valid_o),
    .data_out_o    (data_out_o),
    .status_o      (status_o),
    .occupancy_o   (occupancy_o)
  );

  function automatic deque_result_t deque_apply(input logic [MODE_W-1:0] m,
                                                input logic [DATA_W-1:0] v);
    deque_result_t r;
    int hit;
    r.data = DATA_NONE;
    r.status = ST_OK;
    hit = -1;
    case (m)
      MODE_PUSH_BACK: begin
        if (model_entries.size() >= DQ_DEPTH) r.status = ST_FULL;
        else model_entries.push_back(v);
      end
      MODE_PUSH_FRONT: begin
        if (model_entries.size() >= DQ_DEPTH) r.status = ST_FULL;
        else model_entries.push_front(v);
      end
      MODE_POP_BACK: begin
        if (model_entries.size() == 0) begin
          r.data = DATA_EMPTY;
          r.status = ST_EMPTY;
        end else begin
          r.data = model_entries.pop_back();
        end
      end
      MODE_POP_FRONT: begin
        if (model_entries.size() == 0) begin
          r.data = DATA_EMPTY;
          r.status = ST_EMPTY;
        end else begin
          r.data = model_entries.pop_front();
        end
      end
      MODE_DELETE: begin
        // first match counted from the front, later entries close the gap
        for (int i = 0; i < model_entries.size() && hit < 0; i++)
          if (model_entries[i] == v) hit = i;
        if (hit >= 0) begin
          model_entries.delete(hit);
          r.status = ST_OK;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(model_entries.size());
    return r;
  endfunction

  // call right after a rising edge; returns at the edge that takes the transaction
  task automatic send_request(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v,
                              input logic typed, input deque_result_t typed_res);
    deque_result_t r;
    start_i <= 1'b1;
    mode_i <= m;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
    r = deque_apply(m, v);
    if (typed) r = typed_res;
    pending_results.push_back(r);
  endtask

  task automatic idle_burst();
    int n;
    n = $urandom_range(7, 1);
    start_i <= 1'b0;
    mode_i <= MODE_W'($urandom_range(MODE_UNUSED_HI, 0));
    value_i <= $urandom;
    repeat (n) @(posedge clk_i);
  endtask

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result data_out %h status %0d occupancy %0d",
                 $time, data_out_o, status_o, occupancy_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (data_out_o !== want.data) begin
          $display("%0t data_out expected %h got %h", $time, want.data, data_out_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t status expected %0d got %0d", $time, want.status, status_o);
          errors++;
        end
        if (occupancy_o !== want.occ) begin
          $display("%0t occupancy expected %0d got %0d", $time, want.occ, occupancy_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with neither a request nor a result taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) begin
        stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
        $display("%0t watchdog expired, %0d results outstanding", $time,
                 pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_count <= stall_count + 1;
      end
    end
  end

  initial begin
    deque_result_t no_res;
    logic [MODE_W-1:0] m;
    logic [DATA_W-1:0] v;
    int phase;
    int r;
    int push_w;
    int pop_w;
    int count;

    no_res = '0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hffff_ffff;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7fff_ffff;
    value_pool[4] = 32'h0000_0001;
    value_pool[5] = 32'h5a5a_5a5a;

    // empty queue corner cases first, then both extremes at both ends
    dir_rows[0]  = '{MODE_POP_BACK,   32'h0,          1'b1, '{DATA_EMPTY, ST_EMPTY, 7'd0}};
    dir_rows[1]  = '{MODE_POP_FRONT,  32'h0,          1'b1, '{DATA_EMPTY, ST_EMPTY, 7'd0}};
    dir_rows[2]  = '{MODE_DELETE,     32'h0,          1'b1, '{DATA_NONE, ST_NOT_FOUND, 7'd0}};
    dir_rows[3]  = '{MODE_UNUSED_LO,  32'hffff_ffff,  1'b1, '{DATA_NONE, ST_OK, 7'd0}};
    dir_rows[4]  = '{MODE_UNUSED_MID, 32'h0,          1'b1, '{DATA_NONE, ST_OK, 7'd0}};
    dir_rows[5]  = '{MODE_UNUSED_HI,  32'h8000_0000,  1'b1, '{DATA_NONE, ST_OK, 7'd0}};
    dir_rows[6]  = '{MODE_PUSH_BACK,  32'h7fff_ffff,  1'b1, '{DATA_NONE, ST_OK, 7'd1}};
    dir_rows[7]  = '{MODE_PUSH_FRONT, 32'h8000_0000,  1'b1, '{DATA_NONE, ST_OK, 7'd2}};
    dir_rows[8]  = '{MODE_PUSH_BACK,  32'hffff_ffff,  1'b1, '{DATA_NONE, ST_OK, 7'd3}};
    dir_rows[9]  = '{MODE_PUSH_FRONT, 32'h0,          1'b1, '{DATA_NONE, ST_OK, 7'd4}};
    dir_rows[10] = '{MODE_DELETE,     32'h1234_5678,  1'b1, '{DATA_NONE, ST_NOT_FOUND, 7'd4}};
    dir_rows[11] = '{MODE_DELETE,     32'h8000_0000,  1'b0, no_res};
    dir_rows[12] = '{MODE_POP_FRONT,  32'h0,          1'b0, no_res};
    dir_rows[13] = '{MODE_POP_BACK,   32'h0,          1'b0, no_res};
    dir_rows[14] = '{MODE_PUSH_BACK,  32'h5555_5555,  1'b0, no_res};
    dir_rows[15] = '{MODE_PUSH_BACK,  32'haaaa_aaaa,  1'b0, no_res};
    dir_rows[16] = '{MODE_PUSH_BACK,  32'h5555_5555,  1'b0, no_res};
    // duplicate value: only the one nearest the front goes
    dir_rows[17] = '{MODE_DELETE,     32'h5555_5555,  1'b0, no_res};
    dir_rows[18] = '{MODE_DELETE,     32'h7fff_ffff,  1'b0, no_res};
    dir_rows[19] = '{MODE_DELETE,     32'h5555_5555,  1'b0, no_res};
    dir_rows[20] = '{MODE_UNUSED_HI,  32'hffff_ffff,  1'b0, no_res};
    dir_rows[21] = '{MODE_POP_BACK,   32'h0,          1'b0, no_res};
    dir_rows[22] = '{MODE_POP_FRONT,  32'h0,          1'b0, no_res};

    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = '0;
    value_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DIR_N; k++) begin
      send_request(dir_rows[k].mode, dir_rows[k].value, dir_rows[k].typed, dir_rows[k].res);
      if ($urandom_range(3) == 0) idle_burst();
    end

    // phases: balanced, fill to full, delete heavy, drain, fill, balanced without idling
    count = 0;
    while (count < RAND_ITEMS) begin
      phase = count * PHASES / RAND_ITEMS;
      case (phase)
        1, 4:    begin push_w = 75; pop_w = 10; end
        2:       begin push_w = 45; pop_w = 10; end
        3:       begin push_w = 15; pop_w = 70; end
        default: begin push_w = 40; pop_w = 35; end
      endcase
      r = $urandom_range(99);
      if (r < 3) begin
        m = MODE_W'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
      end else begin
        r = $urandom_range(99);
        if (r < push_w) m = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        else if (r < push_w + pop_w) m = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
        else m = MODE_DELETE;
        count++;
      end
      r = $urandom_range(99);
      if (m == MODE_DELETE && model_entries.size() > 0 && r < 50)
        v = model_entries[$urandom_range(model_entries.size() - 1)];
      else if (r < 80)
        v = value_pool[$urandom_range(POOL_N - 1)];
      else
        v = $urandom;
      send_request(m, v, 1'b0, no_res);
      if (phase != PHASES - 1 && ((count / 40) % 3) != 2 && $urandom_range(3) == 0)
        idle_burst();
    end
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
